// File: rtl/core/vgp_pkg.sv
package vgp_pkg;

  localparam int MAX_DIM     = 128;
  localparam int MAX_WINDOW  = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 25;
  localparam int POS_BITS    = 7;
  localparam int DIM_BITS    = 8;
  localparam int WIN_BITS    = 4;
  localparam int SLOT_BITS   = 2 * POS_BITS;
  localparam int ACC_DEPTH   = MAX_DIM * MAX_DIM;
  localparam int CNT_BITS    = 10;
  localparam int IDX_BITS    = 3;
  localparam int STEP_BITS   = 5;

  typedef enum logic [IDX_BITS-1:0] {
    REG_GRID_X    = 3'd0,
    REG_GRID_Y    = 3'd1,
    REG_GRID_Z    = 3'd2,
    REG_WIN_X     = 3'd3,
    REG_WIN_Y     = 3'd4,
    REG_WIN_Z     = 3'd5,
    REG_POOL_MODE = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIV,
    ST_OUT
  } state_t;

  // clamped grid geometry
  typedef struct packed {
    logic [DIM_BITS-1:0] nx;
    logic [DIM_BITS-1:0] ny;
    logic [DIM_BITS-1:0] nz;
    logic [WIN_BITS-1:0] kx;
    logic [WIN_BITS-1:0] ky;
    logic [WIN_BITS-1:0] kz;
  } grid_cfg_t;

  // what the current voxel means for its window
  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic                 first;
    logic                 last;
    logic                 done;
    logic [CNT_BITS-1:0]  count;
  } pos_info_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    if (v == '0) r = DIM_BITS'(1);
    else if (v > DIM_BITS'(MAX_DIM)) r = DIM_BITS'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  function automatic logic [WIN_BITS-1:0] clamp_win(input logic [WIN_BITS-1:0] v);
    logic [WIN_BITS-1:0] r;
    if (v == '0) r = WIN_BITS'(1);
    else if (v > WIN_BITS'(MAX_WINDOW)) r = WIN_BITS'(MAX_WINDOW);
    else r = v;
    return r;
  endfunction

endpackage

// File: rtl/core/vgp_acc_ram.sv
module vgp_acc_ram import vgp_pkg::*; (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [SLOT_BITS-1:0]       rd_addr,
  output logic signed [ACC_BITS-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [SLOT_BITS-1:0]       wr_addr,
  input  logic signed [ACC_BITS-1:0] wr_data
);

  logic signed [ACC_BITS-1:0] mem [ACC_DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/vgp_pos.sv
module vgp_pos import vgp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      clear,
  input  logic      advance,
  input  grid_cfg_t cfg,
  output pos_info_t info
);

  logic [POS_BITS-1:0] x, y, z;
  logic [WIN_BITS-1:0] xm, ym, zm;
  logic [POS_BITS-1:0] col, row;
  logic [POS_BITS-1:0] sx, sy, sz;
  logic end_x, end_y, end_z;
  logic wl_x, wl_y, wl_z;
  logic [DIM_BITS-1:0] rest_x, rest_y, rest_z;
  logic [WIN_BITS-1:0] ex, ey, ez;
  logic [CNT_BITS-1:0] exy;

  // edge flags
  assign end_x = ({1'b0, x} == cfg.nx - DIM_BITS'(1));
  assign end_y = ({1'b0, y} == cfg.ny - DIM_BITS'(1));
  assign end_z = ({1'b0, z} == cfg.nz - DIM_BITS'(1));
  assign wl_x  = (xm == cfg.kx - WIN_BITS'(1));
  assign wl_y  = (ym == cfg.ky - WIN_BITS'(1));
  assign wl_z  = (zm == cfg.kz - WIN_BITS'(1));

  // voxels of the window that lie inside the grid
  assign rest_x = cfg.nx - {1'b0, sx};
  assign rest_y = cfg.ny - {1'b0, sy};
  assign rest_z = cfg.nz - {1'b0, sz};
  assign ex = (rest_x < {4'b0, cfg.kx}) ? rest_x[WIN_BITS-1:0] : cfg.kx;
  assign ey = (rest_y < {4'b0, cfg.ky}) ? rest_y[WIN_BITS-1:0] : cfg.ky;
  assign ez = (rest_z < {4'b0, cfg.kz}) ? rest_z[WIN_BITS-1:0] : cfg.kz;
  assign exy = CNT_BITS'(ex) * CNT_BITS'(ey);

  always_comb begin
    info.slot  = {row, col};
    info.first = (xm == '0) && (ym == '0) && (zm == '0);
    info.last  = (wl_x || end_x) && (wl_y || end_y) && (wl_z || end_z);
    info.done  = end_x && end_y && end_z;
    info.count = exy * CNT_BITS'(ez);
  end

  // raster walk with window-relative counters
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      x <= '0; y <= '0; z <= '0;
      xm <= '0; ym <= '0; zm <= '0;
      col <= '0; row <= '0;
      sx <= '0; sy <= '0; sz <= '0;
    end else if (advance) begin
      if (end_x) begin
        x <= '0; xm <= '0; col <= '0; sx <= '0;
        if (end_y) begin
          y <= '0; ym <= '0; row <= '0; sy <= '0;
          if (end_z) begin
            z <= '0; zm <= '0; sz <= '0;
          end else if (wl_z) begin
            z <= z + POS_BITS'(1); zm <= '0;
            sz <= POS_BITS'({1'b0, sz} + {4'b0, cfg.kz});
          end else begin
            z <= z + POS_BITS'(1); zm <= zm + WIN_BITS'(1);
          end
        end else if (wl_y) begin
          y <= y + POS_BITS'(1); ym <= '0; row <= row + POS_BITS'(1);
          sy <= POS_BITS'({1'b0, sy} + {4'b0, cfg.ky});
        end else begin
          y <= y + POS_BITS'(1); ym <= ym + WIN_BITS'(1);
        end
      end else if (wl_x) begin
        x <= x + POS_BITS'(1); xm <= '0; col <= col + POS_BITS'(1);
        sx <= POS_BITS'({1'b0, sx} + {4'b0, cfg.kx});
      end else begin
        x <= x + POS_BITS'(1); xm <= xm + WIN_BITS'(1);
      end
    end
  end

endmodule

// File: rtl/core/vgp_div.sv
module vgp_div import vgp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [ACC_BITS-1:0]    dividend,
  input  logic [CNT_BITS-1:0]           divisor,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  logic [ACC_BITS-1:0]  mag;
  logic [CNT_BITS-1:0]  rem, dvs;
  logic                 neg, run;
  logic [STEP_BITS-1:0] cnt;
  logic [CNT_BITS:0]    trial, diff;
  logic                 ge;
  logic [CNT_BITS-1:0]  rem_next;

  // one restoring step per cycle
  assign trial    = {rem, mag[ACC_BITS-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign rem_next = ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == '0);
      if (start) begin
        run <= 1'b1;
        cnt <= STEP_BITS'(ACC_BITS - 1);
      end else if (run) begin
        if (cnt == '0) run <= 1'b0;
        else cnt <= cnt - STEP_BITS'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[ACC_BITS-1];
      mag <= dividend[ACC_BITS-1] ? ACC_BITS'(-dividend) : ACC_BITS'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      mag <= {mag[ACC_BITS-2:0], ge};
      rem <= rem_next;
    end
  end

  // sign fix, truncated toward zero
  assign quotient = neg ? SAMPLE_BITS'(-mag[SAMPLE_BITS-1:0]) : mag[SAMPLE_BITS-1:0];

endmodule

// File: rtl/core/voxel_grid_max_avg_pool_3d_unit.sv
// 3d max / average pooling over a dense voxel grid streamed in raster order
// (x fastest, then y, then z). s_tdata carries one signed q7.8 voxel per beat.
// m_tdata carries one pooled q7.8 result per finished window, in output raster
// order; m_tlast marks the final result of the grid.
// configuration: cfg_we / cfg_index / cfg_data write grid sizes, window
// extents and pool mode; writing one of these restarts the grid at the origin.
// each voxel is accepted in the idle state, then a read-modify-write of the
// window accumulator memory (one write port, one registered read port) runs
// before the next voxel can be taken. a voxel that closes a window in max
// mode then loads the output register; in average mode the 25-step serial
// divider runs first, and no voxel is taken until the result is loaded.
// reset clears position, configuration and handshake state; the accumulator
// memory is not cleared, since every window overwrites its entry first.
// when the receiver stalls, the output register holds; the next voxel is still
// taken and processed, and a following result waits until the register frees.
module voxel_grid_max_avg_pool_3d_unit import vgp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // [15:0] voxel_value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,   // [15:0] pooled_value
  output logic                   m_tlast,   // grid_done
  input  logic                   cfg_we,
  input  logic [IDX_BITS-1:0]    cfg_index,
  input  logic [DIM_BITS-1:0]    cfg_data
);

  logic [DIM_BITS-1:0] gsx, gsy, gsz;
  logic [WIN_BITS-1:0] wx, wy, wz;
  logic                pool_mode;
  grid_cfg_t           gcfg;
  pos_info_t           pinfo, cur;

  state_t state, state_next;
  logic   s_accept;
  logic signed [ACC_BITS-1:0]    v_ext, acc_rd, acc_new;
  logic                          clear;
  logic                          div_start, div_done;
  logic signed [SAMPLE_BITS-1:0] div_q;
  logic [SAMPLE_BITS-1:0]        res;
  logic                          out_free, load_out;
  logic signed [SAMPLE_BITS-1:0] v_reg;

  assign s_accept = s_tvalid && s_tready;
  assign clear    = cfg_we && (cfg_index <= REG_POOL_MODE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gsx <= DIM_BITS'(1); gsy <= DIM_BITS'(1); gsz <= DIM_BITS'(1);
      wx <= WIN_BITS'(1); wy <= WIN_BITS'(1); wz <= WIN_BITS'(1);
      pool_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_X:    gsx <= cfg_data;
        REG_GRID_Y:    gsy <= cfg_data;
        REG_GRID_Z:    gsz <= cfg_data;
        REG_WIN_X:     wx <= cfg_data[WIN_BITS-1:0];
        REG_WIN_Y:     wy <= cfg_data[WIN_BITS-1:0];
        REG_WIN_Z:     wz <= cfg_data[WIN_BITS-1:0];
        REG_POOL_MODE: pool_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gcfg.nx = clamp_dim(gsx);
    gcfg.ny = clamp_dim(gsy);
    gcfg.nz = clamp_dim(gsz);
    gcfg.kx = clamp_win(wx);
    gcfg.ky = clamp_win(wy);
    gcfg.kz = clamp_win(wz);
  end

  vgp_pos u_pos (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .advance (s_accept),
    .cfg     (gcfg),
    .info    (pinfo)
  );

  vgp_acc_ram u_ram (
    .clk     (clk),
    .rd_en   (s_accept),
    .rd_addr (pinfo.slot),
    .rd_data (acc_rd),
    .wr_en   (state == ST_MOD),
    .wr_addr (cur.slot),
    .wr_data (acc_new)
  );

  // capture the accepted voxel and its window info
  always_ff @(posedge clk) begin
    if (s_accept) begin
      v_reg <= s_tdata;
      cur   <= pinfo;
    end
  end

  // accumulator update
  assign v_ext = ACC_BITS'(v_reg);
  always_comb begin
    if (cur.first) acc_new = v_ext;
    else if (pool_mode) acc_new = (v_ext > acc_rd) ? v_ext : acc_rd;
    else acc_new = acc_rd + v_ext;
  end

  assign div_start = (state == ST_MOD) && cur.last && !pool_mode;

  vgp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_new),
    .divisor  (cur.count),
    .done     (div_done),
    .quotient (div_q)
  );

  // result holding register
  always_ff @(posedge clk) begin
    if ((state == ST_MOD) && cur.last && pool_mode) res <= acc_new[SAMPLE_BITS-1:0];
    else if ((state == ST_DIV) && div_done) res <= div_q;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_accept) state_next = ST_MOD;
      ST_MOD: begin
        if (!cur.last) state_next = ST_IDLE;
        else if (pool_mode) state_next = ST_OUT;
        else state_next = ST_DIV;
      end
      ST_DIV:  if (div_done) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = (state == ST_IDLE);
    out_free = !m_tvalid || m_tready;
    load_out = (state == ST_OUT) && out_free;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= res;
      m_tlast <= cur.done;
    end
  end

endmodule

// File: rtl/core/vgp_checker.sv
module vgp_checker import vgp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // nothing pending after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a voxel beat is followed by its memory update, never a second beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("voxel accepted back to back");

  // stalled result stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped under stall");

  // stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed under stall");

endmodule

bind voxel_grid_max_avg_pool_3d_unit vgp_checker u_vgp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: dv/voxel_grid_max_avg_pool_3d_unit_tb.sv
`timescale 1ns / 100ps

module voxel_grid_max_avg_pool_3d_unit_tb;
  import vgp_pkg::*;

  // pooled result as it leaves the block
  typedef struct {
    logic [15:0] value;
    logic        done;
  } pooled_t;

  // pooling predictor with its own copy of geometry, position and window store
  class pool_scoreboard;
    logic [DIM_BITS-1:0] size_x, size_y, size_z;
    logic [WIN_BITS-1:0] win_x, win_y, win_z;
    bit mode_max;
    int px, py, pz;
    longint acc [int];
    pooled_t pending [$];
    int errors;

    function void reset_state();
      size_x = 1; size_y = 1; size_z = 1;
      win_x = 1; win_y = 1; win_z = 1;
      mode_max = 0;
      px = 0; py = 0; pz = 0;
      pending.delete();
      errors = 0;
    endfunction

    function int clip(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] data);
      case (reg_index_t'(idx))
        REG_GRID_X:    size_x = data;
        REG_GRID_Y:    size_y = data;
        REG_GRID_Z:    size_z = data;
        REG_WIN_X:     win_x = data[WIN_BITS-1:0];
        REG_WIN_Y:     win_y = data[WIN_BITS-1:0];
        REG_WIN_Z:     win_z = data[WIN_BITS-1:0];
        REG_POOL_MODE: mode_max = data[0];
        default:       return;
      endcase
      px = 0; py = 0; pz = 0;
    endfunction

    function int extent(int p, int k, int n);
      int rest;
      rest = n - (p / k) * k;
      return rest < k ? rest : k;
    endfunction

    // note an accepted voxel, queue a result if it closes a window
    function void take_voxel(logic signed [15:0] sample);
      int nx, ny, nz, kx, ky, kz, slot, cnt;
      longint v, r;
      bit first, lx, ly, lz;
      pooled_t res;
      nx = clip(size_x, MAX_DIM); ny = clip(size_y, MAX_DIM); nz = clip(size_z, MAX_DIM);
      kx = clip(win_x, MAX_WINDOW); ky = clip(win_y, MAX_WINDOW); kz = clip(win_z, MAX_WINDOW);
      v = sample;
      if (px >= nx) px = 0;
      if (py >= ny) py = 0;
      if (pz >= nz) pz = 0;
      slot = (py / ky) * MAX_DIM + px / kx;
      first = (px % kx == 0) && (py % ky == 0) && (pz % kz == 0);
      if (first || !acc.exists(slot)) acc[slot] = v;
      else if (mode_max) begin
        if (v > acc[slot]) acc[slot] = v;
      end else acc[slot] += v;
      lx = (px % kx == kx - 1) || (px == nx - 1);
      ly = (py % ky == ky - 1) || (py == ny - 1);
      lz = (pz % kz == kz - 1) || (pz == nz - 1);
      if (lx && ly && lz) begin
        r = acc[slot];
        if (!mode_max) begin
          cnt = extent(px, kx, nx) * extent(py, ky, ny) * extent(pz, kz, nz);
          r = r / cnt;
        end
        res.value = r[15:0];
        res.done = (px == nx - 1) && (py == ny - 1) && (pz == nz - 1);
        pending.push_back(res);
      end
      px++;
      if (px >= nx) begin
        px = 0; py++;
        if (py >= ny) begin
          py = 0; pz++;
          if (pz >= nz) pz = 0;
        end
      end
    endfunction

    function void check_result(logic [15:0] value, logic done);
      pooled_t exp_res;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h done %b", value, done);
        return;
      end
      exp_res = pending.pop_front();
      if (exp_res.value !== value || exp_res.done !== done) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h/%b got %h/%b", exp_res.value, exp_res.done,
                   value, done);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast, cfg_we;
  logic [15:0] s_tdata, m_tdata;
  logic [IDX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0] cfg_data;

  pool_scoreboard sb;
  int src_idle_pct, snk_idle_pct;
  longint cycles;

  voxel_grid_max_avg_pool_3d_unit uut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("voxel_grid_max_avg_pool_3d_unit_tb failed");
        $finish;
      end
    end
  end

  // result side: random stall and checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic write_cfg(reg_index_t idx, int data);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= data[DIM_BITS-1:0];
    @(posedge clk);
    sb.write_reg(idx, data[DIM_BITS-1:0]);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // drain the results, then let a divide in flight settle
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // the block is busy the cycle after a beat, so the gap costs no throughput
  task automatic send_voxel(logic [15:0] v);
    while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    s_tvalid <= 1; s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_voxel(v);
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic setup(int gx, int gy, int gz, int wx, int wy, int wz, int mode);
    wait_idle();
    write_cfg(REG_GRID_X, gx); write_cfg(REG_GRID_Y, gy); write_cfg(REG_GRID_Z, gz);
    write_cfg(REG_WIN_X, wx); write_cfg(REG_WIN_Y, wy); write_cfg(REG_WIN_Z, wz);
    write_cfg(REG_POOL_MODE, mode);
  endtask

  function automatic logic [15:0] rand_voxel();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic run_grid(int gx, int gy, int gz, int n);
    setup(gx, gy, gz, $urandom_range(8), $urandom_range(8), $urandom_range(8),
          $urandom_range(1));
    repeat (n) send_voxel(rand_voxel());
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    src_idle_pct = 35; snk_idle_pct = 86;
    rst = 1; s_tvalid = 0; s_tdata = 0; m_tready = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset geometry, extremes, partial windows, out of range registers
    send_voxel(16'h7fff); send_voxel(16'h8000);
    setup(3, 3, 1, 2, 2, 1, 0);
    repeat (9) send_voxel(16'h8000);
    setup(3, 2, 1, 2, 2, 0, 1);
    send_voxel(16'h8000); send_voxel(16'h7fff); repeat (4) send_voxel(16'hffff);
    setup(0, 255, 1, 15, 9, 1, 0);
    write_cfg(REG_GRID_Y, 2);
    // unlisted register index: ignored
    cfg_we <= 1; cfg_index <= 3'd7; cfg_data <= 8'hff;
    @(posedge clk);
    sb.write_reg(3'd7, 8'hff);
    cfg_we <= 0;
    send_voxel(16'h0001); send_voxel(16'hfffd); send_voxel(16'h0005);
    // random grids over three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin src_idle_pct = 86; snk_idle_pct = 35; end
      if (ph == 2) begin src_idle_pct = 0; snk_idle_pct = 0; end
      for (int g = 0; g < 7; g++) begin
        int gx, gy, gz;
        gx = $urandom_range(1, 9); gy = $urandom_range(1, 5); gz = $urandom_range(1, 3);
        run_grid(gx, gy, gz, gx * gy * gz + $urandom_range(gx * gy));
      end
    end
    // widest rows, full grid
    setup(128, 2, 1, 8, 2, 1, 1);
    repeat (2 * 128) send_voxel(rand_voxel());
    setup(200, 1, 1, 8, 1, 1, 0);
    repeat (130) send_voxel(rand_voxel());
    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("voxel_grid_max_avg_pool_3d_unit_tb passed");
    else
      $display("voxel_grid_max_avg_pool_3d_unit_tb failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/vgp_pkg.sv
rtl/core/vgp_acc_ram.sv
rtl/core/vgp_pos.sv
rtl/core/vgp_div.sv
rtl/core/voxel_grid_max_avg_pool_3d_unit.sv
rtl/core/vgp_checker.sv
dv/voxel_grid_max_avg_pool_3d_unit_tb.sv
